[rtl/positional_list_store_macros.svh]
// Assertion helpers used by the bound assertion checker.
`ifndef POSITIONAL_LIST_STORE_MACROS_SVH
`define POSITIONAL_LIST_STORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define PLST_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define PLST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/plst_pkg.sv]
`default_nettype none
package plst_pkg;

    localparam int Capacity = 32;
    localparam int IdxW     = $clog2(Capacity);
    localparam int CntW     = $clog2(Capacity + 1);
    localparam int DataW    = 32;
    localparam int PosW     = 16;
    localparam int CmdW     = 3;
    localparam int StatW    = 2;
    localparam int SizeW    = 7;

    localparam logic [CmdW-1:0] CmdAddHead = 3'd0;
    localparam logic [CmdW-1:0] CmdAddTail = 3'd1;
    localparam logic [CmdW-1:0] CmdInsert  = 3'd2;
    localparam logic [CmdW-1:0] CmdDelete  = 3'd3;
    localparam logic [CmdW-1:0] CmdClear   = 3'd4;
    localparam logic [CmdW-1:0] CmdDump    = 3'd5;

    localparam logic [StatW-1:0] StOk      = 2'd0;
    localparam logic [StatW-1:0] StInvalid = 2'd1;
    localparam logic [StatW-1:0] StFull    = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load;   // capture the input item
        logic exec;   // run a single-result command
        logic emit;   // emit one dump element
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
        logic is_dump;
        logic empty;
        logic dump_last;
    } t_stat;

endpackage
`default_nettype wire

[rtl/plst_ctrl.sv]
`default_nettype none
module plst_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  wire plst_pkg::t_stat i_stat,
    output plst_pkg::t_cmd   o_cmd
);

    localparam logic StIdle = 1'b0;
    localparam logic StBusy = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            StIdle: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = StBusy;
                end
            end
            StBusy: begin
                if (i_stat.out_free) begin
                    if (i_stat.is_dump && !i_stat.empty) begin
                        o_cmd.emit = 1'b1;
                        if (i_stat.dump_last) begin
                            n_state = StIdle;
                        end
                    end else begin
                        o_cmd.exec = 1'b1;
                        n_state    = StIdle;
                    end
                end
            end
            default: begin
                n_state = StIdle;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StIdle;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

[rtl/plst_dp.sv]
`default_nettype none
module plst_dp (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire plst_pkg::t_cmd               i_cmd,
    output plst_pkg::t_stat                   o_stat,
    input  wire  [plst_pkg::CmdW-1:0]         i_command,
    input  wire  [plst_pkg::DataW-1:0]        i_data_in,
    input  wire  [plst_pkg::PosW-1:0]         i_position,
    input  wire                               i_out_ready,
    output logic                              o_out_valid,
    output logic [plst_pkg::StatW-1:0]        o_status,
    output logic [plst_pkg::SizeW-1:0]        o_list_size,
    output logic [plst_pkg::DataW-1:0]        o_data_out,
    output logic                              o_data_valid,
    output logic                              o_last
);

    logic [plst_pkg::CmdW-1:0]  r_cmd;
    logic [plst_pkg::DataW-1:0] r_data;
    logic [plst_pkg::PosW-1:0]  r_pos;
    logic [plst_pkg::CntW-1:0]  r_count;
    logic [plst_pkg::CntW-1:0]  n_count;
    logic [plst_pkg::IdxW-1:0]  r_rd_idx;
    logic [plst_pkg::DataW-1:0] r_cell [plst_pkg::Capacity];
    logic [plst_pkg::DataW-1:0] n_cell [plst_pkg::Capacity];

    logic                       full;
    logic                       del_ok;
    logic                       op_ins;
    logic                       op_del;
    logic [plst_pkg::CntW-1:0]  ins_idx;
    logic [plst_pkg::CntW-1:0]  op_idx;
    logic [plst_pkg::StatW-1:0] exec_status;

    logic                       r_out_valid;
    logic [plst_pkg::StatW-1:0] r_status;
    logic [plst_pkg::SizeW-1:0] r_size;
    logic [plst_pkg::DataW-1:0] r_dout;
    logic                       r_dvalid;
    logic                       r_last;

    assign full    = (r_count == plst_pkg::CntW'(plst_pkg::Capacity));
    assign del_ok  = !r_pos[plst_pkg::PosW-1]
                     && (r_pos < plst_pkg::PosW'(r_count));
    assign ins_idx = (r_pos >= plst_pkg::PosW'(r_count)) ? r_count
                                                         : r_pos[plst_pkg::CntW-1:0];

    always_comb begin
        op_ins      = 1'b0;
        op_del      = 1'b0;
        op_idx      = '0;
        exec_status = plst_pkg::StOk;
        n_count     = r_count;
        case (r_cmd)
            plst_pkg::CmdAddHead: begin
                op_idx = '0;
                if (full) exec_status = plst_pkg::StFull;
                else op_ins = 1'b1;
            end
            plst_pkg::CmdAddTail: begin
                op_idx = r_count;
                if (full) exec_status = plst_pkg::StFull;
                else op_ins = 1'b1;
            end
            plst_pkg::CmdInsert: begin
                op_idx = ins_idx;
                if (r_pos[plst_pkg::PosW-1]) exec_status = plst_pkg::StInvalid;
                else if (full) exec_status = plst_pkg::StFull;
                else op_ins = 1'b1;
            end
            plst_pkg::CmdDelete: begin
                op_idx = r_pos[plst_pkg::CntW-1:0];
                if (!del_ok) exec_status = plst_pkg::StInvalid;
                else op_del = 1'b1;
            end
            plst_pkg::CmdClear: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
        if (op_ins) n_count = r_count + 1'b1;
        if (op_del) n_count = r_count - 1'b1;
    end

    // shifting cells: each one looks only at itself, its neighbors and the input item
    always_comb begin
        for (int i = 0; i < plst_pkg::Capacity; i++) begin
            n_cell[plst_pkg::IdxW'(i)] = r_cell[plst_pkg::IdxW'(i)];
            if (op_ins) begin
                if (plst_pkg::CntW'(i) == op_idx) begin
                    n_cell[plst_pkg::IdxW'(i)] = r_data;
                end else if (i > 0 && plst_pkg::CntW'(i) > op_idx) begin
                    n_cell[plst_pkg::IdxW'(i)] = r_cell[plst_pkg::IdxW'(i - 1)];
                end
            end else if (op_del) begin
                if (i < plst_pkg::Capacity - 1 && plst_pkg::CntW'(i) >= op_idx) begin
                    n_cell[plst_pkg::IdxW'(i)] = r_cell[plst_pkg::IdxW'(i + 1)];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_cell <= n_cell;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= i_command;
            r_data <= i_data_in;
            r_pos  <= i_position;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_rd_idx <= '0;
        end else begin
            if (i_cmd.exec) r_count <= n_count;
            if (i_cmd.load) r_rd_idx <= '0;
            else if (i_cmd.emit) r_rd_idx <= r_rd_idx + 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec || i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= exec_status;
            r_size   <= plst_pkg::SizeW'(n_count);
            r_dout   <= '0;
            r_dvalid <= 1'b0;
            r_last   <= 1'b1;
        end else if (i_cmd.emit) begin
            r_status <= plst_pkg::StOk;
            r_size   <= plst_pkg::SizeW'(r_count);
            r_dout   <= r_cell[r_rd_idx];
            r_dvalid <= 1'b1;
            r_last   <= o_stat.dump_last;
        end
    end

    assign o_stat.out_free  = !r_out_valid || i_out_ready;
    assign o_stat.is_dump   = (r_cmd == plst_pkg::CmdDump);
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.dump_last = ((plst_pkg::CntW'(r_rd_idx) + 1'b1) == r_count);

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_list_size  = r_size;
    assign o_data_out   = r_dout;
    assign o_data_valid = r_dvalid;
    assign o_last       = r_last;

endmodule
`default_nettype wire

[rtl/positional_list_store.sv]
// positional_list_store: ordered list of up to 32 signed 32-bit values.
// Input stream (s_axis): one item per command. tuser carries the command
// (add head, add tail, insert, delete, clear, dump); tdata carries the value
// and the position. Output stream (m_axis): result items. tuser carries the
// status and a data-valid flag, tdata the list size and the element value,
// tlast marks the final result of a command.
// Every command gives one result, except a dump of a non-empty list, which
// gives one result per element from head to tail.
// Timing: an item is taken in the idle state; in the busy state, once the
// result register is free, the command runs (all cells shift at once) and
// its result is registered. A dump emits its elements one by one from the
// busy state. The block returns to idle, and takes a new item, only after
// the last result of a command is registered (one command at a time).
// The result register lets the next item be accepted while a result waits.
// Stall: while m_axis_tready is low the result holds and the block waits.
// Reset (i_rst_n low, synchronous) empties the list and drops any result.
`default_nettype none
module positional_list_store (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [47:0] i_s_axis_tdata,   // data_in[31:0], position[47:32]
    input  wire  [2:0]  i_s_axis_tuser,   // command[2:0]
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // list_size[6:0], data_out[38:7], zero[39]
    output logic [2:0]  o_m_axis_tuser,   // status[1:0], data_valid[2]
    output logic        o_m_axis_tlast
);

    plst_pkg::t_cmd                 cmd;
    plst_pkg::t_stat                stat;
    logic [plst_pkg::StatW-1:0]     status;
    logic [plst_pkg::SizeW-1:0]     list_size;
    logic [plst_pkg::DataW-1:0]     data_out;
    logic                           data_valid;

    plst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    plst_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_command    (i_s_axis_tuser),
        .i_data_in    (i_s_axis_tdata[31:0]),
        .i_position   (i_s_axis_tdata[47:32]),
        .i_out_ready  (i_m_axis_tready),
        .o_out_valid  (o_m_axis_tvalid),
        .o_status     (status),
        .o_list_size  (list_size),
        .o_data_out   (data_out),
        .o_data_valid (data_valid),
        .o_last       (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {1'b0, data_out, list_size};
    assign o_m_axis_tuser = {data_valid, status};

endmodule
`default_nettype wire

[rtl/plst_checker.sv]
`default_nettype none
`include "positional_list_store_macros.svh"
module plst_assertions (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_m_axis_tready,
    input wire        o_m_axis_tvalid,
    input wire [39:0] o_m_axis_tdata,
    input wire [2:0]  o_m_axis_tuser,
    input wire        o_m_axis_tlast
);

    `PLST_ASSERT_NEXT(a_stall_holds, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))

    `PLST_ASSERT_NOW(a_size_bound, o_m_axis_tvalid, o_m_axis_tdata[6:0] <= 7'(plst_pkg::Capacity))

    `PLST_ASSERT_NOW(a_nodata_last, o_m_axis_tvalid && !o_m_axis_tuser[2], o_m_axis_tlast && (o_m_axis_tdata[38:7] == 32'd0))

    `PLST_ASSERT_NOW(a_full_size, o_m_axis_tvalid && (o_m_axis_tuser[1:0] == plst_pkg::StFull), o_m_axis_tdata[6:0] == 7'(plst_pkg::Capacity))

    `PLST_ASSERT_NOW(a_dump_ok, o_m_axis_tvalid && o_m_axis_tuser[2], (o_m_axis_tuser[1:0] == plst_pkg::StOk) && (o_m_axis_tdata[6:0] != 7'd0))

endmodule

bind positional_list_store plst_assertions u_plst_checker (.*);
`default_nettype wire

[test/plst_checker.sv]
`default_nettype none
module plst_checker
    import plst_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    input  wire         i_s_tready,
    input  wire  [47:0] i_s_tdata,   // data_in[31:0], position[47:32]
    input  wire  [2:0]  i_s_tuser,   // command[2:0]
    input  wire         i_m_tvalid,
    input  wire         i_m_tready,
    input  wire  [39:0] i_m_tdata,   // list_size[6:0], data_out[38:7], zero[39]
    input  wire  [2:0]  i_m_tuser,   // status[1:0], data_valid[2]
    input  wire         i_m_tlast,
    output int          o_mismatches,
    output int          o_outstanding
);

    typedef struct packed {
        logic [StatW-1:0] status;
        logic [SizeW-1:0] size;
        logic [DataW-1:0] value;
        logic             valid;
        logic             last;
    } t_list_result;

    logic [DataW-1:0] cells [Capacity];
    int               count = 0;
    t_list_result     due_results [$];
    t_list_result     got;
    t_list_result     want;
    int               mismatches = 0;

    assign o_mismatches = mismatches;

    function automatic t_list_result result_item(logic [StatW-1:0] st, logic [DataW-1:0] value,
                                                 logic valid, logic last);
        t_list_result r;
        r.status = st;
        r.size   = SizeW'(count);
        r.value  = value;
        r.valid  = valid;
        r.last   = last;
        return r;
    endfunction

    function automatic logic [StatW-1:0] insert_cell(int idx, logic [DataW-1:0] value);
        int i;
        if (count >= Capacity) return StFull;
        if (idx > count) idx = count;
        for (i = count; i > idx; i--) cells[i] = cells[i-1];
        cells[idx] = value;
        count++;
        return StOk;
    endfunction

    function automatic logic [StatW-1:0] delete_cell(int idx);
        int i;
        if (idx >= count) return StInvalid;
        for (i = idx; i + 1 < count; i++) cells[i] = cells[i+1];
        count--;
        return StOk;
    endfunction

    function automatic void run_command(logic [CmdW-1:0] cmd, logic [DataW-1:0] value,
                                        logic [PosW-1:0] pos);
        logic [StatW-1:0] st;
        int               idx;
        int               i;
        st  = StOk;
        idx = int'(pos[PosW-2:0]);
        case (cmd)
            CmdAddHead: st = insert_cell(0, value);
            CmdAddTail: st = insert_cell(count, value);
            CmdInsert:  st = pos[PosW-1] ? StInvalid : insert_cell(idx, value);
            CmdDelete:  st = pos[PosW-1] ? StInvalid : delete_cell(idx);
            CmdClear:   count = 0;
            CmdDump: begin
                for (i = 0; i < count; i++)
                    due_results.push_back(result_item(StOk, cells[i], 1'b1, i + 1 == count));
                if (count > 0) return;
            end
            default: ;
        endcase
        due_results.push_back(result_item(st, '0, 1'b0, 1'b1));
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            due_results.delete();
            count = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.status = i_m_tuser[1:0];
                got.size   = i_m_tdata[6:0];
                got.value  = i_m_tdata[38:7];
                got.valid  = i_m_tuser[2];
                got.last   = i_m_tlast;
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result st=%0d size=%0d data=%h dv=%b last=%b",
                             $time, got.status, got.size, got.value, got.valid, got.last);
                    mismatches++;
                end else begin
                    want = due_results.pop_front();
                    if (got !== want || i_m_tdata[39] !== 1'b0) begin
                        $display("%0t: expected st=%0d size=%0d data=%h dv=%b last=%b",
                                 $time, want.status, want.size, want.value, want.valid,
                                 want.last);
                        $display("%0t: actual   st=%0d size=%0d data=%h dv=%b last=%b pad=%b",
                                 $time, got.status, got.size, got.value, got.valid, got.last,
                                 i_m_tdata[39]);
                        mismatches++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                run_command(i_s_tuser, i_s_tdata[31:0], i_s_tdata[47:32]);
        end
        o_outstanding <= due_results.size();
    end

endmodule
`default_nettype wire

[test/tb_top.sv]
`default_nettype none
module tb_top
    import plst_pkg::*;
;

    localparam logic [CmdW-1:0] CmdSpareA  = 3'd6;
    localparam logic [CmdW-1:0] CmdSpareB  = 3'd7;
    localparam int              PhaseItems = 105;
    localparam int              Limit      = 500000;
    localparam int              HoldCycles = 200;

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [47:0] i_s_axis_tdata  = '0;  // data_in[31:0], position[47:32]
    logic [2:0]  i_s_axis_tuser  = '0;  // command[2:0]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [39:0] o_m_axis_tdata;        // list_size[6:0], data_out[38:7], zero[39]
    logic [2:0]  o_m_axis_tuser;        // status[1:0], data_valid[2]
    logic        o_m_axis_tlast;

    int   mismatches;
    int   outstanding;
    int   idle_pct  = 0;
    int   stall_pct = 0;
    logic rx_hold   = 1'b0;
    logic hold_req  = 1'b0;
    int   cycle_cnt = 0;

    positional_list_store u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    plst_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_axis_tvalid),
        .i_s_tready    (o_s_axis_tready),
        .i_s_tdata     (i_s_axis_tdata),
        .i_s_tuser     (i_s_axis_tuser),
        .i_m_tvalid    (o_m_axis_tvalid),
        .i_m_tready    (i_m_axis_tready),
        .i_m_tdata     (o_m_axis_tdata),
        .i_m_tuser     (o_m_axis_tuser),
        .i_m_tlast     (o_m_axis_tlast),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_m_axis_tready <= !rx_hold && ($urandom_range(0, 99) >= stall_pct);
    end

    // long receiver hold-off while the sender keeps pushing
    initial begin
        wait (hold_req);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HoldCycles) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin
        while (cycle_cnt < Limit) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("tb_top: errors");
        $finish;
    end

    task automatic send_item(input logic [CmdW-1:0] cmd, input logic [DataW-1:0] value,
                             input logic [PosW-1:0] pos);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {pos, value};
        i_s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    initial begin
        int               phase;
        int               n;
        int               pick;
        logic [CmdW-1:0]  cmd;
        logic [DataW-1:0] value;
        logic [PosW-1:0]  pos;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(CmdDump,    32'h0,         16'd0);
        send_item(CmdDelete,  32'h0,         16'd0);
        send_item(CmdInsert,  32'h1234_5678, 16'hFFFF);
        send_item(CmdAddHead, 32'h7FFF_FFFF, 16'd0);
        send_item(CmdAddTail, 32'h8000_0000, 16'd0);
        send_item(CmdInsert,  32'h0000_0000, 16'd0);
        send_item(CmdInsert,  32'hFFFF_FFFF, 16'h7FFF);
        send_item(CmdInsert,  32'h0000_0001, 16'd2);
        send_item(CmdInsert,  32'hA5A5_5A5A, 16'd5);
        send_item(CmdDump,    32'h0,         16'd0);
        send_item(CmdDelete,  32'h0,         16'h8000);
        send_item(CmdDelete,  32'h0,         16'd6);
        send_item(CmdDelete,  32'h0,         16'd5);
        send_item(CmdDelete,  32'h0,         16'd0);
        send_item(CmdDelete,  32'h0,         16'hFFFF);
        send_item(CmdSpareA,  32'hFFFF_FFFF, 16'hFFFF);
        send_item(CmdSpareB,  32'h0,         16'd0);
        send_item(CmdDump,    32'h0,         16'd0);
        send_item(CmdClear,   32'h0,         16'd0);
        send_item(CmdDump,    32'h0,         16'd0);
        send_item(CmdDelete,  32'h0,         16'd0);

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    idle_pct  <= 0;
                    stall_pct <= 0;
                    hold_req  <= 1'b1;
                end
                1: begin
                    idle_pct  <= 53;
                    stall_pct <= 0;
                end
                2: begin
                    idle_pct  <= 0;
                    stall_pct <= 53;
                end
                default: begin
                    idle_pct  <= 38;
                    stall_pct <= 38;
                end
            endcase
            for (n = 0; n < PhaseItems; n++) begin
                pick  = $urandom_range(0, 99);
                value = $urandom;
                if ($urandom_range(0, 9) < 8) pos = PosW'($urandom_range(0, 34));
                else pos = PosW'($urandom);
                if (pick < 14) cmd = CmdAddHead;
                else if (pick < 28) cmd = CmdAddTail;
                else if (pick < 44) cmd = CmdInsert;
                else if (pick < 70) cmd = CmdDelete;
                else if (pick < 74) cmd = CmdClear;
                else if (pick < 88) cmd = CmdDump;
                else if (pick < 90) cmd = $urandom_range(0, 1) ? CmdSpareA : CmdSpareB;
                else cmd = CmdDelete;
                send_item(cmd, value, pos);
            end
        end
        i_s_axis_tvalid <= 1'b0;

        do @(posedge i_clk); while (outstanding != 0);
        repeat (20) @(posedge i_clk);

        if (mismatches == 0 && outstanding == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
`default_nettype wire

[filelist.f]
+incdir+rtl
rtl/plst_pkg.sv
rtl/plst_ctrl.sv
rtl/plst_dp.sv
rtl/positional_list_store.sv
rtl/plst_checker.sv
test/plst_checker.sv
test/tb_top.sv
